// ----- hw/rtl/dcd_pkg.sv -----
`default_nettype none

package dcd_pkg;

    // configuration port geometry
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index taken from the word address
    localparam logic REG_SYNC_FULL_CODE = 1'b0;

    localparam int OPCODE_W = 6;
    localparam int COUNT_W  = 5;

    localparam logic [OPCODE_W-1:0] SYNC_FULL_RESET = 6'd41;
    localparam logic [OPCODE_W-1:0] FORWARD_MIN     = 6'd8;

    typedef struct packed {
        logic [31:0] word_high;
        logic [31:0] word_low;
    } dcd_in_t;

    typedef struct packed {
        logic [31:0]         out_high;
        logic [31:0]         out_low;
        logic [OPCODE_W-1:0] opcode;
        logic                forward;
        logic                first_word;
        logic                last_word;
        logic                sync_full;
    } dcd_out_t;

    // command length in words for each opcode
    function automatic logic [COUNT_W-1:0] cmd_length(input logic [OPCODE_W-1:0] code);
        logic [COUNT_W-1:0] len;
        case (code)
            6'd8:    len = 5'd4;
            6'd9:    len = 5'd6;
            6'd10:   len = 5'd12;
            6'd11:   len = 5'd14;
            6'd12:   len = 5'd12;
            6'd13:   len = 5'd14;
            6'd14:   len = 5'd20;
            6'd15:   len = 5'd22;
            6'd36:   len = 5'd2;
            6'd37:   len = 5'd2;
            default: len = 5'd1;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dcd_apb_regs.sv -----
`default_nettype none

module dcd_apb_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dcd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [dcd_pkg::PDATA_W-1:0] pwdata,
    output logic      [dcd_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output logic      [dcd_pkg::OPCODE_W-1:0] sync_full_code
);
    import dcd_pkg::*;

    logic [OPCODE_W-1:0] sync_code_reg;
    logic                wr_en;
    logic                reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1];
    assign wr_en     = psel && penable && pwrite && pready;

    // register write, low opcode bits kept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_code_reg <= SYNC_FULL_RESET;
        end else if (wr_en && reg_index == REG_SYNC_FULL_CODE) begin
            sync_code_reg <= pwdata[OPCODE_W-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (reg_index == REG_SYNC_FULL_CODE) begin
            prdata[OPCODE_W-1:0] = sync_code_reg;
        end
    end

    assign sync_full_code = sync_code_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dcd_core.sv -----
`default_nettype none

module dcd_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [dcd_pkg::OPCODE_W-1:0] sync_full_code,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire dcd_pkg::dcd_in_t             s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output dcd_pkg::dcd_out_t                 m_data
);
    import dcd_pkg::*;

    dcd_in_t             in_data_reg;
    logic                in_valid_reg;
    dcd_out_t            out_data_reg;
    dcd_out_t            out_next;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  words_left_reg;
    logic [COUNT_W-1:0]  words_left_next;
    logic [OPCODE_W-1:0] held_opcode_reg;
    logic [OPCODE_W-1:0] held_opcode_next;
    logic                out_free;
    logic                move;
    logic                first;
    logic                last;

    // handshake between the two stages
    assign out_free = !out_valid_reg || m_ready;
    assign move     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || move;

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // command framing: new opcode and length at command start
    always_comb begin
        first = (words_left_reg == '0);
        if (first) begin
            held_opcode_next = in_data_reg.word_high[29:24];
            words_left_next  = cmd_length(in_data_reg.word_high[29:24]) - 5'd1;
        end else begin
            held_opcode_next = held_opcode_reg;
            words_left_next  = words_left_reg - 5'd1;
        end
        last = (words_left_next == '0);

        out_next.out_high   = in_data_reg.word_high;
        out_next.out_low    = in_data_reg.word_low;
        out_next.opcode     = held_opcode_next;
        out_next.forward    = (held_opcode_next >= FORWARD_MIN);
        out_next.first_word = first;
        out_next.last_word  = last;
        out_next.sync_full  = last && (held_opcode_next == sync_full_code);
    end

    // framing state advances once per passed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_left_reg  <= '0;
            held_opcode_reg <= '0;
        end else if (move) begin
            words_left_reg  <= words_left_next;
            held_opcode_reg <= held_opcode_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_data_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/display_command_deframer_unit.sv -----
`default_nettype none

// Display command deframer. Each 64-bit command word accepted on s_ is
// passed out on m_ unchanged, tagged with its command's opcode (bits 61:56
// of the first word), first and last word marks, a forward flag (opcode 8
// or more) and a sync-full pulse on the last word of a command whose opcode
// equals the sync_full_code register (byte address 0, reset 41). One word
// is taken every cycle while m_ready is high; a word passes through an input
// register and then a result register before its result appears on m_.
// Command lengths come from a fixed opcode table and a 5-bit count of the
// words still missing. Write sync_full_code only while idle.
module display_command_deframer_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dcd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [dcd_pkg::PDATA_W-1:0]  pwdata,
    output logic      [dcd_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire dcd_pkg::dcd_in_t             s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output dcd_pkg::dcd_out_t                 m_data
);
    import dcd_pkg::*;

    logic [OPCODE_W-1:0] sync_full_code;

    // configuration registers
    dcd_apb_regs u_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .sync_full_code (sync_full_code)
    );

    // word tagging pipeline
    dcd_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sync_full_code (sync_full_code),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

`default_nettype wire
